/* rtl/wpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared constants and types for the WAV PCM16 stream decoder.
// ----------------------------------------------------------------------------
package wpd_pkg;

    // RIFF chunk tags, as little-endian 32-bit words
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Bytes of the fmt chunk that hold the fields we read
    localparam logic [31:0] FMT_FIELD_BYTES = 32'd16;
    localparam logic [15:0] PCM_FORMAT_TAG  = 16'd1;
    localparam logic [15:0] PCM_BITS        = 16'd16;

    // Result event codes
    localparam logic [1:0] EV_FRAME  = 2'd0;
    localparam logic [1:0] EV_HEADER = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_RIFF   = 3'd1;
    localparam logic [2:0] ERR_NOT_WAVE   = 3'd2;
    localparam logic [2:0] ERR_NO_FMT     = 3'd3;
    localparam logic [2:0] ERR_COMPRESSED = 3'd4;
    localparam logic [2:0] ERR_NOT_16BIT  = 3'd5;
    localparam logic [2:0] ERR_CHANNELS   = 3'd6;
    localparam logic [2:0] ERR_EOF        = 3'd7;

    // Channel count marker for an unsupported count
    localparam logic [1:0] CH_INVALID = 2'd3;
    localparam logic [1:0] CH_MONO    = 2'd1;
    localparam logic [1:0] CH_STEREO  = 2'd2;

    // One result item
    typedef struct packed {
        logic [1:0]         event_res;
        logic [2:0]         error_code;
        logic [31:0]        sample_rate;
        logic [1:0]         channel_count;
        logic [30:0]        frame_count;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               last_frame;
    } wpd_res_t;

endpackage

/* rtl/wav_pcm16_stream_decoder_core.sv */
`timescale 1ns / 1ps
// Path: a byte accepted into the input register is parsed combinationally and
// its result (if any) is written into the result buffer, whose head drives the output.
// Throughput: one byte per cycle while the consumer keeps up; the whole parse
// step for a byte sits in one stage between the input register and the
// two-entry result buffer, which stalls the input only when both entries wait.
// Reset: rst_n is asynchronous, active low; the parser returns to expecting
// the RIFF tag, and the input register and the result buffer come up empty.
// ----------------------------------------------------------------------------
// wav_pcm16_stream_decoder_core
// WAV PCM16 byte-stream decoder: header checks, chunk skipping and
// left/right Q1.15 frame output.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_decoder_core
    import wpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_file,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         event_res,
    output logic [2:0]         error_code,
    output logic [31:0]        sample_rate,
    output logic [1:0]         channel_count,
    output logic [30:0]        frame_count,
    output logic signed [15:0] left_sample,
    output logic signed [15:0] right_sample,
    output logic               last_frame
);

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       eof_reg;
    logic       space;
    logic       fire;
    logic       res_valid;
    wpd_res_t   res;
    wpd_res_t   head;

    // Input register advances when the result buffer has room
    assign fire     = in_valid_reg && space;
    assign in_ready = !in_valid_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= data_byte;
            eof_reg  <= end_of_file;
        end
    end

    wpd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (fire),
        .data_byte   (byte_reg),
        .end_of_file (eof_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    wpd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Result fields to ports
    assign event_res     = head.event_res;
    assign error_code    = head.error_code;
    assign sample_rate   = head.sample_rate;
    assign channel_count = head.channel_count;
    assign frame_count   = head.frame_count;
    assign left_sample   = head.left_sample;
    assign right_sample  = head.right_sample;
    assign last_frame    = head.last_frame;

endmodule

/* rtl/wpd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpd_parser
// Byte-wise RIFF/WAVE header parser and PCM16 frame assembler. Holds all
// parse state; produces at most one result per byte, combinationally.
// ----------------------------------------------------------------------------
module wpd_parser
    import wpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    output logic       res_valid,
    output wpd_res_t   res
);

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_FMTID,
        PH_FMTSIZE,
        PH_FMTBODY,
        PH_SKIP,
        PH_CKID,
        PH_DSIZE,
        PH_OSIZE,
        PH_DATA,
        PH_END,
        PH_ERR
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [3:0]  idx_reg,      idx_next;
    logic [31:0] word_reg,     word_next;
    logic [31:0] skip_reg,     skip_next;
    logic [31:0] fmt_left_reg, fmt_left_next;
    logic [1:0]  chan_reg,     chan_next;
    logic [31:0] rate_reg,     rate_next;
    logic [30:0] frames_reg,   frames_next;
    logic [15:0] left_reg,     left_next;

    logic [31:0] word_shift;
    logic [15:0] half;
    logic [3:0]  idx_inc;
    logic        word_done;
    logic        stereo;
    logic [30:0] frames_dec;
    logic [31:0] skip_dec;
    logic [31:0] fmt_rest;
    logic [30:0] frame_total;

    // Shared datapath pieces
    assign word_shift  = {data_byte, word_reg[31:8]};
    assign half        = word_shift[31:16];
    assign idx_inc     = idx_reg + 4'd1;
    assign word_done   = (idx_reg == 4'd3);
    assign stereo      = (chan_reg == CH_STEREO);
    assign frames_dec  = frames_reg - 31'd1;
    assign skip_dec    = skip_reg - 32'd1;
    assign fmt_rest    = (fmt_left_reg > FMT_FIELD_BYTES) ?
                         (fmt_left_reg - FMT_FIELD_BYTES) : 32'd0;
    assign frame_total = stereo ? {1'b0, word_shift[31:3], 1'b0} : word_shift[31:1];

    // Next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        word_next     = word_reg;
        skip_next     = skip_reg;
        fmt_left_next = fmt_left_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        frames_next   = frames_reg;
        left_next     = left_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (item_valid && (phase_reg != PH_END) && (phase_reg != PH_ERR))
        begin
            if (end_of_file)
            begin
                if (phase_reg == PH_DATA)
                begin
                    phase_next = PH_END;
                end
                else
                begin
                    phase_next     = PH_ERR;
                    res_valid      = 1'b1;
                    res.event_res  = EV_ERROR;
                    res.error_code = ERR_EOF;
                end
            end
            else
            begin
                word_next = word_shift;
                unique case (phase_reg)
                    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMTID, PH_FMTSIZE,
                    PH_CKID, PH_OSIZE, PH_DSIZE:
                    begin
                        idx_next = word_done ? 4'd0 : idx_inc;
                        if (word_done)
                        begin
                            unique case (phase_reg)
                                PH_RIFF:
                                begin
                                    if (word_shift != TAG_RIFF)
                                    begin
                                        phase_next     = PH_ERR;
                                        res_valid      = 1'b1;
                                        res.event_res  = EV_ERROR;
                                        res.error_code = ERR_NOT_RIFF;
                                    end
                                    else
                                    begin
                                        phase_next = PH_RSIZE;
                                    end
                                end
                                PH_RSIZE:
                                begin
                                    phase_next = PH_WAVE;
                                end
                                PH_WAVE:
                                begin
                                    if (word_shift != TAG_WAVE)
                                    begin
                                        phase_next     = PH_ERR;
                                        res_valid      = 1'b1;
                                        res.event_res  = EV_ERROR;
                                        res.error_code = ERR_NOT_WAVE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_FMTID;
                                    end
                                end
                                PH_FMTID:
                                begin
                                    if (word_shift != TAG_FMT)
                                    begin
                                        phase_next     = PH_ERR;
                                        res_valid      = 1'b1;
                                        res.event_res  = EV_ERROR;
                                        res.error_code = ERR_NO_FMT;
                                    end
                                    else
                                    begin
                                        phase_next = PH_FMTSIZE;
                                    end
                                end
                                PH_FMTSIZE:
                                begin
                                    fmt_left_next = word_shift;
                                    phase_next    = PH_FMTBODY;
                                end
                                PH_CKID:
                                begin
                                    phase_next = (word_shift == TAG_DATA) ? PH_DSIZE : PH_OSIZE;
                                end
                                PH_OSIZE:
                                begin
                                    skip_next  = word_shift;
                                    phase_next = (word_shift != 32'd0) ? PH_SKIP : PH_CKID;
                                end
                                PH_DSIZE:
                                begin
                                    frames_next       = frame_total;
                                    phase_next        = (frame_total != 31'd0) ? PH_DATA : PH_END;
                                    res_valid         = 1'b1;
                                    res.event_res     = EV_HEADER;
                                    res.sample_rate   = rate_reg;
                                    res.channel_count = chan_reg;
                                    res.frame_count   = frame_total;
                                end
                                default:
                                begin
                                    phase_next = phase_reg;
                                end
                            endcase
                        end
                    end

                    // Fixed 16-byte field area of the fmt chunk
                    PH_FMTBODY:
                    begin
                        idx_next = idx_inc;
                        if ((idx_reg == 4'd1) && (half != PCM_FORMAT_TAG))
                        begin
                            phase_next     = PH_ERR;
                            res_valid      = 1'b1;
                            res.event_res  = EV_ERROR;
                            res.error_code = ERR_COMPRESSED;
                        end
                        if (idx_reg == 4'd3)
                        begin
                            chan_next = ((half == 16'd1) || (half == 16'd2)) ?
                                        half[1:0] : CH_INVALID;
                        end
                        if (idx_reg == 4'd7)
                        begin
                            rate_next = word_shift;
                        end
                        if (idx_reg == 4'd15)
                        begin
                            idx_next = 4'd0;
                            if (half != PCM_BITS)
                            begin
                                phase_next     = PH_ERR;
                                res_valid      = 1'b1;
                                res.event_res  = EV_ERROR;
                                res.error_code = ERR_NOT_16BIT;
                            end
                            else if ((chan_reg != CH_MONO) && (chan_reg != CH_STEREO))
                            begin
                                phase_next     = PH_ERR;
                                res_valid      = 1'b1;
                                res.event_res  = EV_ERROR;
                                res.error_code = ERR_CHANNELS;
                            end
                            else
                            begin
                                skip_next  = fmt_rest;
                                phase_next = (fmt_rest != 32'd0) ? PH_SKIP : PH_CKID;
                            end
                        end
                    end

                    // Skip body of an unwanted chunk or the fmt tail
                    PH_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 32'd0)
                        begin
                            phase_next = PH_CKID;
                        end
                    end

                    // Sample bytes: two per mono frame, four per stereo frame
                    PH_DATA:
                    begin
                        idx_next = idx_inc;
                        if (stereo && (idx_inc == 4'd2))
                        begin
                            left_next = half;
                        end
                        else if (idx_inc >= (stereo ? 4'd4 : 4'd2))
                        begin
                            idx_next         = 4'd0;
                            frames_next      = frames_dec;
                            res_valid        = 1'b1;
                            res.event_res    = EV_FRAME;
                            res.left_sample  = stereo ? left_reg : half;
                            res.right_sample = half;
                            res.last_frame   = (frames_dec == 31'd0);
                            if (frames_dec == 31'd0)
                            begin
                                phase_next = PH_END;
                            end
                        end
                    end

                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RIFF;
            idx_reg      <= '0;
            word_reg     <= '0;
            skip_reg     <= '0;
            fmt_left_reg <= '0;
            chan_reg     <= '0;
            rate_reg     <= '0;
            frames_reg   <= '0;
            left_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            word_reg     <= word_next;
            skip_reg     <= skip_next;
            fmt_left_reg <= fmt_left_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            frames_reg   <= frames_next;
            left_reg     <= left_next;
        end
    end

    // Errors latch until reset
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERR) |=> (phase_reg == PH_ERR))
        else $error("parser left the error state");

    // An error result always moves the parser into the error state
    a_err_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.event_res == EV_ERROR)) |=> (phase_reg == PH_ERR))
        else $error("error result without entering error state");

    // Frames are only produced while a supported channel count is held
    a_frame_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.event_res == EV_FRAME)) |->
        ((chan_reg == CH_MONO) || (chan_reg == CH_STEREO)))
        else $error("frame emitted with invalid channel count");

endmodule

/* rtl/wpd_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpd_out_buf
// Two-entry result buffer. The head entry drives the output port; the second
// entry absorbs one result while the consumer stalls.
// ----------------------------------------------------------------------------
module wpd_out_buf
    import wpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  wpd_res_t push_data,
    output logic     space,
    output logic     out_valid,
    input  logic     out_ready,
    output wpd_res_t head
);

    logic [1:0] count_reg, count_next;
    wpd_res_t   head_reg,  head_next;
    wpd_res_t   tail_reg,  tail_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;
    assign head      = head_reg;

    // Buffer occupancy and entry moves
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next  = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    head_next = push_data;
                end
                else if (push)
                begin
                    tail_next  = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            default:
            begin
                if (pop)
                begin
                    head_next  = tail_reg;
                    count_next = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Entries carry no reset
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !push)
        else $error("result pushed into a full buffer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd3))
        else $error("buffer count out of range");

    // A waiting item stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(head_reg)))
        else $error("output item changed while stalled");

endmodule

/* tb/sv/wav_pcm16_stream_decoder_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_pcm16_stream_decoder_core_test
// Feeds the decoder one generated WAV file, byte by byte. Each run picks the
// file's shape at random: mono or stereo, short, exact or long fmt chunk,
// extra chunks to skip, and a data size that is exact, oversized (cut short by
// end of file) or zero. About one run in five carries a header fault instead.
// A cycle-free parser model predicts every header, frame and error item, and
// each output item is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_decoder_core_test;
    import wpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int FLOW_SPAN      = 150;
    localparam int ITEM_TARGET    = 1250;
    localparam logic [15:0] PEAK_SAMPLES [0:5] =
        '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00};

    typedef enum int {FLOW_FREE, FLOW_SENDER_GAPS, FLOW_SINK_STALLS, FLOW_BOTH_LIGHT} flow_t;

    // ------------------------------------------------------------------------
    // Parser model and store of expected output items
    // ------------------------------------------------------------------------
    class wav_decode_checker;
        typedef enum logic [3:0] {
            S_RIFF_TAG, S_RIFF_SIZE, S_WAVE_TAG, S_FMT_ID, S_FMT_SIZE, S_FMT_BODY,
            S_SKIP, S_CHUNK_ID, S_DATA_SIZE, S_OTHER_SIZE, S_DATA, S_DONE, S_FAILED
        } parse_state_t;

        parse_state_t state;
        logic [4:0]   byte_idx;
        logic [31:0]  word_acc;
        logic [31:0]  skip_left;
        logic [31:0]  fmt_len;
        logic [1:0]   chans;
        logic [31:0]  rate;
        logic [30:0]  frames_left;
        logic [15:0]  left_hold;
        wpd_res_t     expected_q[$];
        int unsigned  mismatches;

        function new();
            state       = S_RIFF_TAG;
            byte_idx    = '0;
            word_acc    = '0;
            skip_left   = '0;
            fmt_len     = '0;
            chans       = '0;
            rate        = '0;
            frames_left = '0;
            left_hold   = '0;
            mismatches  = 0;
        endfunction

        // Counts one byte of a 32-bit field; true once all four are in
        function bit word_complete();
            byte_idx = byte_idx + 5'd1;
            if (byte_idx >= 5'd4) begin
                byte_idx = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void raise_error(logic [2:0] code);
            wpd_res_t r;
            r            = '0;
            r.event_res  = EV_ERROR;
            r.error_code = code;
            state        = S_FAILED;
            expected_q.push_back(r);
        endfunction

        // One accepted input item
        function void note_byte(logic [7:0] b, logic eof);
            wpd_res_t    r;
            logic [15:0] half;
            logic [3:0]  fi;
            r = '0;
            if (state == S_DONE || state == S_FAILED)
                return;
            if (eof) begin
                if (state == S_DATA)
                    state = S_DONE;
                else
                    raise_error(ERR_EOF);
                return;
            end
            word_acc = {b, word_acc[31:8]};
            half     = word_acc[31:16];
            case (state)
                S_RIFF_TAG:
                    if (word_complete()) begin
                        if (word_acc != TAG_RIFF) raise_error(ERR_NOT_RIFF);
                        else state = S_RIFF_SIZE;
                    end
                S_RIFF_SIZE:
                    if (word_complete()) state = S_WAVE_TAG;
                S_WAVE_TAG:
                    if (word_complete()) begin
                        if (word_acc != TAG_WAVE) raise_error(ERR_NOT_WAVE);
                        else state = S_FMT_ID;
                    end
                S_FMT_ID:
                    if (word_complete()) begin
                        if (word_acc != TAG_FMT) raise_error(ERR_NO_FMT);
                        else state = S_FMT_SIZE;
                    end
                S_FMT_SIZE:
                    if (word_complete()) begin
                        fmt_len = word_acc;
                        state   = S_FMT_BODY;
                    end
                S_FMT_BODY:
                begin
                    fi = byte_idx[3:0];
                    if (fi == 4'd1 && half != PCM_FORMAT_TAG) begin
                        raise_error(ERR_COMPRESSED);
                    end
                    else begin
                        if (fi == 4'd3)
                            chans = (half == 16'd1) ? CH_MONO :
                                    (half == 16'd2) ? CH_STEREO : CH_INVALID;
                        if (fi == 4'd7)
                            rate = word_acc;
                        if (fi == 4'd15) begin
                            // bit depth is checked ahead of the channel count
                            if (half != PCM_BITS)
                                raise_error(ERR_NOT_16BIT);
                            else if (chans != CH_MONO && chans != CH_STEREO)
                                raise_error(ERR_CHANNELS);
                            else begin
                                byte_idx  = '0;
                                skip_left = (fmt_len > FMT_FIELD_BYTES) ?
                                            fmt_len - FMT_FIELD_BYTES : '0;
                                state     = (skip_left != 0) ? S_SKIP : S_CHUNK_ID;
                            end
                        end
                        else begin
                            byte_idx = {1'b0, fi + 4'd1};
                        end
                    end
                end
                S_SKIP:
                begin
                    if (skip_left != 0) skip_left = skip_left - 32'd1;
                    if (skip_left == 0) state = S_CHUNK_ID;
                end
                S_CHUNK_ID:
                    if (word_complete())
                        state = (word_acc == TAG_DATA) ? S_DATA_SIZE : S_OTHER_SIZE;
                S_OTHER_SIZE:
                    if (word_complete()) begin
                        skip_left = word_acc;
                        state     = (skip_left != 0) ? S_SKIP : S_CHUNK_ID;
                    end
                S_DATA_SIZE:
                    if (word_complete()) begin
                        // stereo: bytes / 4, rounded down to even
                        if (chans == CH_STEREO)
                            frames_left = {1'b0, word_acc[31:3], 1'b0};
                        else
                            frames_left = word_acc[31:1];
                        state           = (frames_left != 0) ? S_DATA : S_DONE;
                        r.event_res     = EV_HEADER;
                        r.sample_rate   = rate;
                        r.channel_count = chans;
                        r.frame_count   = frames_left;
                        expected_q.push_back(r);
                    end
                S_DATA:
                begin
                    byte_idx = byte_idx + 5'd1;
                    if (chans == CH_STEREO && byte_idx == 5'd2) begin
                        left_hold = half;
                    end
                    else if (byte_idx >= ((chans == CH_STEREO) ? 5'd4 : 5'd2)) begin
                        byte_idx = '0;
                        r.left_sample  = (chans == CH_STEREO) ? left_hold : half;
                        r.right_sample = half;
                        if (frames_left != 0) frames_left = frames_left - 31'd1;
                        if (frames_left == 0) state = S_DONE;
                        r.event_res  = EV_FRAME;
                        r.last_frame = (frames_left == 0);
                        expected_q.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(input string msg);
            $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // One accepted output item
        task check_result(input wpd_res_t got);
            wpd_res_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected item event=%0d err=%0d",
                                 got.event_res, got.error_code));
                return;
            end
            want = expected_q.pop_front();
            if (got.event_res !== want.event_res)
                report($sformatf("event_res %0d, want %0d", got.event_res, want.event_res));
            if (got.error_code !== want.error_code)
                report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
            if (got.sample_rate !== want.sample_rate)
                report($sformatf("sample_rate %h, want %h", got.sample_rate, want.sample_rate));
            if (got.channel_count !== want.channel_count)
                report($sformatf("channel_count %0d, want %0d",
                                 got.channel_count, want.channel_count));
            if (got.frame_count !== want.frame_count)
                report($sformatf("frame_count %h, want %h", got.frame_count, want.frame_count));
            if (got.left_sample !== want.left_sample)
                report($sformatf("left_sample %h, want %h", got.left_sample, want.left_sample));
            if (got.right_sample !== want.right_sample)
                report($sformatf("right_sample %h, want %h",
                                 got.right_sample, want.right_sample));
            if (got.last_frame !== want.last_frame)
                report($sformatf("last_frame %0d, want %0d", got.last_frame, want.last_frame));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte   = 8'h00;
    logic               end_of_file = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [1:0]         event_res;
    logic [2:0]         error_code;
    logic [31:0]        sample_rate;
    logic [1:0]         channel_count;
    logic [30:0]        frame_count;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last_frame;

    wav_decode_checker decode_chk;
    flow_t             idle_mode   = FLOW_FREE;
    int                quiet_cycles = 0;
    logic [8:0]        file_q[$];   // {end_of_file, data_byte}

    wav_pcm16_stream_decoder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_res     (event_res),
        .error_code    (error_code),
        .sample_rate   (sample_rate),
        .channel_count (channel_count),
        .frame_count   (frame_count),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .last_frame    (last_frame)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // File building and byte driving
    // ------------------------------------------------------------------------
    task automatic push_word(input logic [31:0] w, input int n);
        for (int j = 0; j < n; j++)
            file_q.push_back({1'b0, w[8*j +: 8]});
    endtask

    task automatic push_noise(input int n);
        for (int j = 0; j < n; j++)
            file_q.push_back({1'b0, 8'($urandom)});
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        int pct;
        pct = (idle_mode == FLOW_SENDER_GAPS) ? 58 : (idle_mode == FLOW_BOTH_LIGHT) ? 6 : 0;
        while ($urandom_range(0, 99) < pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        do @(posedge clk); while (!in_ready);
        decode_chk.note_byte(b, eof);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure and checking
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        int pct;
        pct = (idle_mode == FLOW_SINK_STALLS) ? 58 : (idle_mode == FLOW_BOTH_LIGHT) ? 6 : 0;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready)
                decode_chk.check_result({event_res, error_code, sample_rate, channel_count,
                                         frame_count, left_sample, right_sample,
                                         last_frame});
            out_ready <= ($urandom_range(0, 99) >= pct);
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [2:0]  fault;
        logic [31:0] riff_tag, wave_tag, fmt_id, rate_val, data_size, ck_id;
        logic [15:0] fmt_tag, chan_field, bits_field;
        logic [7:0]  nz;
        int          ch, data_len, fmt_size, n_other, ck_size, cut, hdr_end, size_pick, k;

        decode_chk = new();

        // Pick the file shape and an optional header fault
        ch         = $urandom_range(1, 2);
        fault      = ($urandom_range(0, 99) < 80) ? ERR_NONE : 3'($urandom_range(1, 7));
        riff_tag   = TAG_RIFF;
        wave_tag   = TAG_WAVE;
        fmt_id     = TAG_FMT;
        fmt_tag    = PCM_FORMAT_TAG;
        bits_field = PCM_BITS;
        chan_field = 16'(ch);
        nz         = 8'($urandom_range(1, 255));
        k          = $urandom_range(0, 3);
        case (fault)
            ERR_NOT_RIFF: riff_tag ^= 32'(nz) << (8 * k);
            ERR_NOT_WAVE: wave_tag ^= 32'(nz) << (8 * k);
            ERR_NO_FMT:   fmt_id   ^= 32'(nz) << (8 * k);
            ERR_COMPRESSED:
                case ($urandom_range(0, 2))
                    0:       fmt_tag = 16'h0000;
                    1:       fmt_tag = 16'hFFFF;
                    default: fmt_tag = 16'(nz) + 16'd1;
                endcase
            ERR_NOT_16BIT:
            begin
                bits_field = $urandom_range(0, 1) ? 16'd8 : {nz, 8'h10};
                // a bad channel count too: bit depth must win
                if ($urandom_range(0, 1)) chan_field = 16'd0;
            end
            ERR_CHANNELS:
                case ($urandom_range(0, 3))
                    0:       chan_field = 16'd0;
                    1:       chan_field = 16'd3;
                    2:       chan_field = 16'hFFFF;
                    default: chan_field = 16'(nz) + 16'd2;
                endcase
            default: ;
        endcase
        case ($urandom_range(0, 4))
            0:       rate_val = 32'h0000_0000;
            1:       rate_val = 32'hFFFF_FFFF;
            2:       rate_val = 32'd44100;
            3:       rate_val = 32'd48000;
            default: rate_val = $urandom;
        endcase
        // fmt size: exact, zero, short, slightly and well over 16
        case ($urandom_range(0, 4))
            0:       fmt_size = 16;
            1:       fmt_size = 0;
            2:       fmt_size = $urandom_range(1, 15);
            3:       fmt_size = 18;
            default: fmt_size = $urandom_range(17, 64);
        endcase

        // RIFF header and fmt chunk
        push_word(riff_tag, 4);
        push_word($urandom, 4);
        push_word(wave_tag, 4);
        push_word(fmt_id, 4);
        push_word(32'(fmt_size), 4);
        push_word(32'(fmt_tag), 2);
        push_word(32'(chan_field), 2);
        push_word(rate_val, 4);
        push_word($urandom, 4);
        push_word($urandom, 2);
        push_word(32'(bits_field), 2);
        if (fmt_size > 16) push_noise(fmt_size - 16);

        // Unknown chunks to skip, odd and zero sizes included
        n_other = $urandom_range(0, 3);
        for (int c = 0; c < n_other; c++) begin
            ck_id = $urandom;
            if (ck_id == TAG_DATA) ck_id ^= 32'h1;
            ck_size = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            push_word(ck_id, 4);
            push_word(32'(ck_size), 4);
            push_noise(ck_size);
        end

        // Data chunk: exact, oversized (cut by end of file) or empty
        data_len  = $urandom_range(1000, 1200);
        size_pick = $urandom_range(0, 9);
        if (size_pick == 0) begin
            data_size = 32'd0;
            data_len  = 6;
        end
        else if (size_pick <= 4) begin
            data_size = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF :
                        32'(data_len + $urandom_range(1, 1 << 20));
        end
        else begin
            data_size = 32'(data_len);
        end
        push_word(TAG_DATA, 4);
        push_word(data_size, 4);
        hdr_end = file_q.size();
        for (int i = 0; i < data_len / 2; i++)
            push_word(32'((i < 6) ? PEAK_SAMPLES[i] : 16'($urandom)), 2);
        if (data_len % 2) push_noise(1);
        if (size_pick > 4) push_noise(3);

        // End of file somewhere before the data header completes
        if (fault == ERR_EOF) begin
            cut = $urandom_range(0, hdr_end - 1);
            while (file_q.size() > cut) void'(file_q.pop_back());
        end
        file_q.push_back({1'b1, 8'($urandom)});

        // Trailing bytes after the decoder has stopped keep the run length up
        while (file_q.size() < ITEM_TARGET) file_q.push_back({1'b0, 8'($urandom)});

        // Reset
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Drive the file, rotating the flow-control pattern
        for (int i = 0; i < file_q.size(); i++) begin
            idle_mode = flow_t'((i / FLOW_SPAN) % 4);
            send_byte(file_q[i][7:0], file_q[i][8]);
        end
        in_valid <= 1'b0;

        // Drain
        while (decode_chk.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (decode_chk.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/wpd_pkg.sv
rtl/wpd_parser.sv
rtl/wpd_out_buf.sv
rtl/wav_pcm16_stream_decoder_core.sv
tb/sv/wav_pcm16_stream_decoder_core_test.sv
